[design/gdfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types and constants of the depth-first graph traversal block.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_DEGREE   = 16;
  localparam int VTX_W        = 4;   // vertex number width
  localparam int VCNT_W       = 5;   // vertex_count register width
  localparam int DEPTH_W      = 5;   // stack depth, holds 0..MAX_VERTICES
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(16);

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_ADD_BAD,
    CMD_START,
    CMD_START_BAD,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
  } cmd_t;

endpackage
`default_nettype wire

[design/gdfs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdfs_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gdfs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/gdfs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdfs_front
// Accepts requests, range-checks vertices against vertex_count, drops unused
// opcodes and queues classified commands for the walker.
// ----------------------------------------------------------------------------
module gdfs_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [gdfs_pkg::VCNT_W-1:0]   cfg_wdata,
  input  wire logic                          s_valid,
  output logic                               s_ready,
  input  wire logic [1:0]                    s_opcode,
  input  wire logic [gdfs_pkg::VTX_W-1:0]    s_from,
  input  wire logic [gdfs_pkg::VTX_W-1:0]    s_to,
  output logic                               q_valid,
  input  wire logic                          q_ready,
  output gdfs_pkg::cmd_t                     q_cmd
);

  logic [gdfs_pkg::VCNT_W-1:0] vertex_count;
  logic [gdfs_pkg::VCNT_W-1:0] lim;
  gdfs_pkg::cmd_t              fifo [gdfs_pkg::QUEUE_DEPTH];
  logic [gdfs_pkg::QPTR_W-1:0] wr_ptr;
  logic [gdfs_pkg::QPTR_W-1:0] rd_ptr;
  logic [gdfs_pkg::QCNT_W-1:0] count;
  gdfs_pkg::cmd_t              cls;
  logic                        keep;
  logic                        a_ok;
  logic                        b_ok;
  logic                        push;
  logic                        pop;

  assign lim = (vertex_count > gdfs_pkg::VCNT_W'(gdfs_pkg::MAX_VERTICES)) ?
               gdfs_pkg::VCNT_W'(gdfs_pkg::MAX_VERTICES) : vertex_count;
  assign a_ok = {1'b0, s_from} < lim;
  assign b_ok = {1'b0, s_to} < lim;

  always_comb begin
    cls.a = s_from;
    cls.b = s_to;
    cls.kind = gdfs_pkg::CMD_CLEAR;
    keep = 1'b1;
    unique case (s_opcode)
      gdfs_pkg::OP_ADD: begin
        cls.kind = (a_ok && b_ok) ? gdfs_pkg::CMD_ADD : gdfs_pkg::CMD_ADD_BAD;
      end
      gdfs_pkg::OP_START: begin
        cls.kind = a_ok ? gdfs_pkg::CMD_START : gdfs_pkg::CMD_START_BAD;
      end
      gdfs_pkg::OP_CLEAR: begin
        cls.kind = gdfs_pkg::CMD_CLEAR;
      end
      default: begin
        keep = 1'b0;  // unused opcode, accepted and dropped
      end
    endcase
  end

  assign s_ready = count != gdfs_pkg::QCNT_W'(gdfs_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_cmd   = fifo[rd_ptr];
  assign push    = s_valid && s_ready && keep;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gdfs_pkg::VCOUNT_RESET;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      if (push) begin
        fifo[wr_ptr] <= cls;
        wr_ptr       <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/gdfs_walk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdfs_walk
// Executes queued commands: stores edges in per-vertex neighbor lists, clears
// the graph, and runs the stack-based preorder walk into an output register.
// ----------------------------------------------------------------------------
module gdfs_walk #(
  parameter int MAX_DEGREE = gdfs_pkg::MAX_DEGREE
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_ready,
  input  wire gdfs_pkg::cmd_t               q_cmd,
  output logic                              m_valid,
  input  wire logic                         m_ready,
  output logic [gdfs_pkg::VTX_W-1:0]        m_vertex,
  output logic                              m_last,
  output logic                              m_error
);

  localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
  localparam int ADDR_W = $clog2(gdfs_pkg::MAX_VERTICES * MAX_DEGREE);
  localparam int VW     = gdfs_pkg::VTX_W;
  localparam int NV     = gdfs_pkg::MAX_VERTICES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_NB,
    S_FIN
  } state_t;

  state_t                           state;
  logic [CNT_W-1:0]                 ncount [gdfs_pkg::MAX_VERTICES];
  logic [gdfs_pkg::MAX_VERTICES-1:0] visited;
  logic [VW-1:0]                    stack_v [gdfs_pkg::MAX_VERTICES];
  logic [CNT_W-1:0]                 stack_i [gdfs_pkg::MAX_VERTICES];
  logic [gdfs_pkg::DEPTH_W-1:0]     depth;
  logic                             error_flag;
  logic [VW-1:0]                    pend;

  logic [VW-1:0]     top;
  logic [VW-1:0]     top_v;
  logic [CNT_W-1:0]  top_i;
  logic [VW-1:0]     cnt_addr;
  logic [CNT_W-1:0]  cnt_sel;
  logic              room;
  logic              out_free;
  logic              out_fire;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VW-1:0]     nb;
  logic              push_ok;

  assign top      = VW'(depth - 1'b1);
  assign top_v    = stack_v[top];
  assign top_i    = stack_i[top];
  assign cnt_addr = (state == S_IDLE) ? q_cmd.a : top_v;
  assign cnt_sel  = ncount[cnt_addr];
  assign room     = cnt_sel < CNT_W'(MAX_DEGREE);
  assign out_free = !m_valid || m_ready;

  assign q_ready = (state == S_IDLE) &&
                   ((q_cmd.kind != gdfs_pkg::CMD_START_BAD) || out_free);

  assign ram_we    = (state == S_IDLE) && q_valid &&
                     (q_cmd.kind == gdfs_pkg::CMD_ADD) && room;
  assign ram_waddr = ADDR_W'(q_cmd.a) * ADDR_W'(MAX_DEGREE) + ADDR_W'(cnt_sel);
  assign ram_re    = (state == S_TOP) && (top_i < cnt_sel);
  assign ram_raddr = ADDR_W'(top_v) * ADDR_W'(MAX_DEGREE) + ADDR_W'(top_i);

  gdfs_ram #(
    .WIDTH (VW),
    .DEPTH (gdfs_pkg::MAX_VERTICES * MAX_DEGREE)
  ) u_nbr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_cmd.b),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (nb)
  );

  assign push_ok = !visited[nb] &&
                   (depth < gdfs_pkg::DEPTH_W'(gdfs_pkg::MAX_VERTICES));

  // a result is loaded into the output register this cycle
  assign out_fire = ((state == S_IDLE) && q_valid && q_ready &&
                     (q_cmd.kind == gdfs_pkg::CMD_START_BAD)) ||
                    ((state == S_NB) && push_ok && out_free) ||
                    ((state == S_FIN) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth      <= '0;
      error_flag <= 1'b0;
      visited    <= '0;
      m_valid    <= 1'b0;
      for (int i = 0; i < gdfs_pkg::MAX_VERTICES; i++) begin
        ncount[i] <= '0;
      end
    end else begin
      if (out_fire) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            case (q_cmd.kind)
              gdfs_pkg::CMD_ADD: begin
                if (room) begin
                  ncount[q_cmd.a] <= cnt_sel + 1'b1;
                end else begin
                  error_flag <= 1'b1;
                end
              end
              gdfs_pkg::CMD_ADD_BAD: begin
                error_flag <= 1'b1;
              end
              gdfs_pkg::CMD_CLEAR: begin
                error_flag <= 1'b0;
                visited    <= '0;
                for (int i = 0; i < gdfs_pkg::MAX_VERTICES; i++) begin
                  ncount[i] <= '0;
                end
              end
              gdfs_pkg::CMD_START_BAD: begin
                error_flag <= 1'b1;
                m_vertex   <= '0;
                m_last     <= 1'b1;
                m_error    <= 1'b1;
              end
              gdfs_pkg::CMD_START: begin
                visited          <= NV'(1) << q_cmd.a;
                pend             <= q_cmd.a;
                stack_v[0]       <= q_cmd.a;
                stack_i[0]       <= '0;
                depth            <= gdfs_pkg::DEPTH_W'(1);
                state            <= S_TOP;
              end
              default: ;
            endcase
          end
        end
        S_TOP: begin
          if (top_i < cnt_sel) begin
            stack_i[top] <= top_i + 1'b1;
            state        <= S_NB;
          end else begin
            depth <= depth - 1'b1;
            if (depth == gdfs_pkg::DEPTH_W'(1)) begin
              state <= S_FIN;
            end
          end
        end
        S_NB: begin
          if (!push_ok) begin
            state <= S_TOP;
          end else if (out_free) begin
            // previous vertex is known not to be last once a new one turns up
            m_vertex            <= pend;
            m_last              <= 1'b0;
            m_error             <= error_flag;
            pend                <= nb;
            visited[nb]         <= 1'b1;
            stack_v[depth[VW-1:0]] <= nb;
            stack_i[depth[VW-1:0]] <= '0;
            depth               <= depth + 1'b1;
            state               <= S_TOP;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_vertex <= pend;
            m_last   <= 1'b1;
            m_error  <= error_flag;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= gdfs_pkg::DEPTH_W'(gdfs_pkg::MAX_VERTICES))
    else $error("walk stack deeper than vertex count");

  a_stack_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOP || state == S_NB) |-> depth != '0)
    else $error("walk step with empty stack");

  a_fin_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> depth == '0)
    else $error("walk finished with entries on stack");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOP || state == S_NB || (state == S_IDLE && q_valid)) |->
    cnt_sel <= CNT_W'(MAX_DEGREE))
    else $error("neighbor count over degree limit");

endmodule
`default_nettype wire

[design/graph_depth_first_traversal.sv]
// Order: an edge or clear request takes effect when the idle walker takes it from
// the queue; a traversal shows its first vertex after the walker passes S_TOP and
// then S_NB or S_FIN, with the output register free.
// Throughput: edge and clear requests one per cycle while the walker is idle;
// a traversal reads each edge from RAM in S_TOP, visits it in S_NB, and pops in S_TOP.
// Reset: synchronous; neighbor counts, visited marks and error flag clear at once.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_depth_first_traversal
// Edge loader and preorder depth-first walker over a small directed graph.
// ----------------------------------------------------------------------------
module graph_depth_first_traversal #(
  parameter int MAX_DEGREE = gdfs_pkg::MAX_DEGREE
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,     // vertex_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // opcode[1:0], from_vertex[5:2], to_vertex[9:6]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // vertex[3:0]
  output logic             m_axis_tlast,  // last
  output logic             m_axis_tuser   // error
);

  logic           q_valid;
  logic           q_ready;
  gdfs_pkg::cmd_t q_cmd;
  logic [3:0]     vertex;

  gdfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_opcode  (s_axis_tdata[1:0]),
    .s_from    (s_axis_tdata[5:2]),
    .s_to      (s_axis_tdata[9:6]),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  gdfs_walk #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_vertex (vertex),
    .m_last   (m_axis_tlast),
    .m_error  (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, vertex};

endmodule
`default_nettype wire
